>>> rtl/bcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types, opcodes and the CRC-32 byte update for the command framer.
// ----------------------------------------------------------------------------
package bcf_pkg;

    // input item kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // command codes on the input channel
    localparam logic [2:0] CMD_VERSION   = 3'd0;
    localparam logic [2:0] CMD_HELP      = 3'd1;
    localparam logic [2:0] CMD_CHIP_ID   = 3'd2;
    localparam logic [2:0] CMD_RDP       = 3'd3;
    localparam logic [2:0] CMD_GO        = 3'd4;
    localparam logic [2:0] CMD_ERASE     = 3'd5;
    localparam logic [2:0] CMD_MEM_WRITE = 3'd6;
    localparam logic [2:0] CMD_UNUSED    = 3'd7;

    // opcodes on the serial link
    localparam logic [7:0] OP_VERSION   = 8'h51;
    localparam logic [7:0] OP_GO        = 8'h55;
    localparam logic [7:0] OP_ERASE     = 8'h56;
    localparam logic [7:0] OP_MEM_WRITE = 8'h57;

    // length bytes (frame length minus one)
    localparam logic [7:0] LEN_SHORT     = 8'd5;
    localparam logic [7:0] LEN_GO        = 8'd9;
    localparam logic [7:0] LEN_ERASE     = 8'd7;
    localparam logic [7:0] LEN_WRITE_OFS = 8'd10;

    localparam logic [7:0] MASS_ERASE_SECTOR = 8'hFF;

    localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_MSB  = 32'h80000000;

    localparam int DESC_BYTES = 7;
    localparam int CRC_BYTES  = 4;

    // one unit of work for the back end: fed bytes, then optional crc
    typedef struct packed {
        logic [DESC_BYTES-1:0][7:0] bytes;
        logic [2:0]                 count;
        logic                       with_crc;
        logic                       crc_init;
    } cmd_desc_t;

    typedef logic [31:0][31:0] crc_cols_t;

    // column i is x^(32+i) mod poly: the 32-step update is linear
    function automatic crc_cols_t crc_make_cols();
        crc_cols_t   cols;
        logic [31:0] v;
        for (int i = 0; i < 32; i++) begin
            v = 32'h1 << i;
            for (int s = 0; s < 32; s++) begin
                if ((v & CRC_MSB) != 32'h0) begin
                    v = (v << 1) ^ CRC_POLY;
                end else begin
                    v = v << 1;
                end
            end
            cols[i] = v;
        end
        return cols;
    endfunction

    localparam crc_cols_t CRC_COLS = crc_make_cols();

    // one byte into the crc: xor into low bits, then 32 shift steps
    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic [31:0] r;
        c = crc ^ {24'h0, b};
        r = 32'h0;
        for (int i = 0; i < 32; i++) begin
            if (c[i]) begin
                r = r ^ CRC_COLS[i];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/bcf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_front
// Accepts input transactions, tracks the open memory write and turns each
// item into a descriptor of bytes for the back end.
// ----------------------------------------------------------------------------
module bcf_front #(
    parameter int MAX_PAYLOAD = 128
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire                      s_kind,
    input  wire  [2:0]               s_command,
    input  wire  [31:0]              s_target_address,
    input  wire  [7:0]               s_sector,
    input  wire  [7:0]               s_sector_count,
    input  wire  [7:0]               s_payload_length,
    input  wire  [7:0]               s_data_byte,
    input  wire                      q_full,
    output logic                     push,
    output bcf_pkg::cmd_desc_t       push_desc
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic       write_open_reg, write_open_next;
    logic [7:0] left_reg, left_next;
    logic       accept;
    logic       produce;
    logic [7:0] len;
    logic [7:0] left_dec;
    logic [7:0] count_byte;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && produce;

    // clamp payload length into 1..MAX_PAYLOAD
    always_comb begin
        if (s_payload_length == 8'd0) begin
            len = 8'd1;
        end else if (s_payload_length > MAX_LEN) begin
            len = MAX_LEN;
        end else begin
            len = s_payload_length;
        end
    end

    assign left_dec   = left_reg - 8'd1;
    assign count_byte = (s_sector == bcf_pkg::MASS_ERASE_SECTOR) ? 8'd0 : s_sector_count;

    // classify the item and build its descriptor
    always_comb begin
        produce         = 1'b0;
        push_desc       = '0;
        write_open_next = write_open_reg;
        left_next       = left_reg;
        if (s_kind == bcf_pkg::KIND_PAYLOAD) begin
            if (write_open_reg) begin
                produce                = 1'b1;
                push_desc.bytes[0]     = s_data_byte;
                push_desc.count        = 3'd1;
                push_desc.with_crc     = (left_dec == 8'd0);
                left_next              = left_dec;
                write_open_next        = (left_dec != 8'd0);
            end
        end else begin
            write_open_next = 1'b0;
            left_next       = 8'd0;
            case (s_command)
                bcf_pkg::CMD_VERSION, bcf_pkg::CMD_HELP,
                bcf_pkg::CMD_CHIP_ID, bcf_pkg::CMD_RDP: begin
                    produce            = 1'b1;
                    push_desc.bytes[0] = bcf_pkg::LEN_SHORT;
                    push_desc.bytes[1] = bcf_pkg::OP_VERSION + {5'd0, s_command};
                    push_desc.count    = 3'd2;
                    push_desc.with_crc = 1'b1;
                    push_desc.crc_init = 1'b1;
                end
                bcf_pkg::CMD_GO: begin
                    produce            = 1'b1;
                    push_desc.bytes[0] = bcf_pkg::LEN_GO;
                    push_desc.bytes[1] = bcf_pkg::OP_GO;
                    push_desc.bytes[2] = s_target_address[7:0];
                    push_desc.bytes[3] = s_target_address[15:8];
                    push_desc.bytes[4] = s_target_address[23:16];
                    push_desc.bytes[5] = s_target_address[31:24];
                    push_desc.count    = 3'd6;
                    push_desc.with_crc = 1'b1;
                    push_desc.crc_init = 1'b1;
                end
                bcf_pkg::CMD_ERASE: begin
                    produce            = 1'b1;
                    push_desc.bytes[0] = bcf_pkg::LEN_ERASE;
                    push_desc.bytes[1] = bcf_pkg::OP_ERASE;
                    push_desc.bytes[2] = s_sector;
                    push_desc.bytes[3] = count_byte;
                    push_desc.count    = 3'd4;
                    push_desc.with_crc = 1'b1;
                    push_desc.crc_init = 1'b1;
                end
                bcf_pkg::CMD_MEM_WRITE: begin
                    produce            = 1'b1;
                    push_desc.bytes[0] = bcf_pkg::LEN_WRITE_OFS + len;
                    push_desc.bytes[1] = bcf_pkg::OP_MEM_WRITE;
                    push_desc.bytes[2] = s_target_address[7:0];
                    push_desc.bytes[3] = s_target_address[15:8];
                    push_desc.bytes[4] = s_target_address[23:16];
                    push_desc.bytes[5] = s_target_address[31:24];
                    push_desc.bytes[6] = len;
                    push_desc.count    = 3'd7;
                    push_desc.with_crc = 1'b0;
                    push_desc.crc_init = 1'b1;
                    write_open_next    = 1'b1;
                    left_next          = len;
                end
                bcf_pkg::CMD_UNUSED: begin
                    produce = 1'b0;
                end
                default: begin
                    produce = 1'b0;
                end
            endcase
        end
    end

    // open write tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_open_reg <= 1'b0;
            left_reg       <= 8'd0;
        end else if (accept) begin
            write_open_reg <= write_open_next;
            left_reg       <= left_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/bcf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_queue
// Two-entry descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
module bcf_queue (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      push,
    input  bcf_pkg::cmd_desc_t       push_desc,
    output logic                     full,
    input  wire                      pop,
    output logic                     empty,
    output bcf_pkg::cmd_desc_t       head
);

    bcf_pkg::cmd_desc_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/bcf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_back
// Walks one descriptor a byte per cycle unless m_ready stalls, runs the CRC-32
// over fed bytes and appends the CRC, into a one-deep output register.
// ----------------------------------------------------------------------------
module bcf_back (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      q_empty,
    input  bcf_pkg::cmd_desc_t       q_head,
    output logic                     pop,
    output logic                     m_valid,
    input  wire                      m_ready,
    output logic [7:0]               m_tx_byte,
    output logic                     m_run_last,
    output logic                     m_frame_end
);

    bcf_pkg::cmd_desc_t desc_reg;
    logic        busy_reg;
    logic [3:0]  idx_reg;
    logic [31:0] crc_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        fend_reg;

    logic        advance;
    logic [3:0]  total;
    logic        is_data;
    logic        is_last;
    logic [3:0]  crc_pos;
    logic [31:0] crc_base;
    logic [7:0]  cur_byte;

    assign advance  = busy_reg && (!valid_reg || m_ready);
    assign total    = {1'b0, desc_reg.count}
                      + (desc_reg.with_crc ? 4'(bcf_pkg::CRC_BYTES) : 4'd0);
    assign is_data  = (idx_reg < {1'b0, desc_reg.count});
    assign is_last  = (idx_reg == total - 4'd1);
    assign crc_pos  = idx_reg - {1'b0, desc_reg.count};
    assign crc_base = (idx_reg == 4'd0 && desc_reg.crc_init) ? bcf_pkg::CRC_INIT : crc_reg;
    assign pop      = !q_empty && (!busy_reg || (advance && is_last));

    // byte select: descriptor byte or crc byte, lsb first
    always_comb begin
        if (is_data) begin
            cur_byte = desc_reg.bytes[idx_reg[2:0]];
        end else begin
            case (crc_pos[1:0])
                2'd0:    cur_byte = crc_reg[7:0];
                2'd1:    cur_byte = crc_reg[15:8];
                2'd2:    cur_byte = crc_reg[23:16];
                default: cur_byte = crc_reg[31:24];
            endcase
        end
    end

    // descriptor sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 4'd0;
        end else if (pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= 4'd0;
        end else if (advance) begin
            if (is_last) begin
                busy_reg <= 1'b0;
                idx_reg  <= 4'd0;
            end else begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            desc_reg <= q_head;
        end
    end

    // crc accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= bcf_pkg::CRC_INIT;
        end else if (advance && is_data) begin
            crc_reg <= bcf_pkg::crc_feed(crc_base, cur_byte);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            byte_reg <= cur_byte;
            last_reg <= is_last;
            fend_reg <= is_last && !is_data;
        end
    end

    assign m_valid     = valid_reg;
    assign m_tx_byte   = byte_reg;
    assign m_run_last  = last_reg;
    assign m_frame_end = fend_reg;

endmodule
`default_nettype wire

>>> rtl/bootloader_command_framer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bootloader_command_framer_unit
// Serial command frame builder for a flash bootloader with CRC-32 trailer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transaction per command header or payload byte.
//   m_* channel: one transaction per byte to send on the serial link;
//   m_run_last marks the last byte an input item causes, m_frame_end the
//   final CRC byte of a frame.
// Path: an item's descriptor is registered in the queue, then in the back
//   end's descriptor register, and its first byte in the output register.
// Throughput: the back end sends one byte per cycle unless m_ready stalls;
//   an item causes 6 bytes for short commands, 8 for erase, 10 for go,
//   7 for a write header, 1 per payload byte and 5 for the last.
//   A two-entry descriptor queue lets the input run ahead of the output.
// Items that cause no bytes (unused code, stray payload) push no descriptor.
// Reset (aresetn low, synchronous) closes any open write, empties the queue
//   and drops the output byte. A stalled m_ready holds the byte in place;
//   s_ready falls once the queue is full.
// ----------------------------------------------------------------------------
module bootloader_command_framer_unit #(
    parameter int MAX_PAYLOAD = 128
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_kind,
    input  wire  [2:0]  s_command,
    input  wire  [31:0] s_target_address,
    input  wire  [7:0]  s_sector,
    input  wire  [7:0]  s_sector_count,
    input  wire  [7:0]  s_payload_length,
    input  wire  [7:0]  s_data_byte,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_run_last,
    output logic        m_frame_end
);

    logic               q_full;
    logic               q_empty;
    logic               push;
    logic               pop;
    bcf_pkg::cmd_desc_t push_desc;
    bcf_pkg::cmd_desc_t q_head;

    // front end: accept and classify
    bcf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_command        (s_command),
        .s_target_address (s_target_address),
        .s_sector         (s_sector),
        .s_sector_count   (s_sector_count),
        .s_payload_length (s_payload_length),
        .s_data_byte      (s_data_byte),
        .q_full           (q_full),
        .push             (push),
        .push_desc        (push_desc)
    );

    // descriptor queue
    bcf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // back end: byte sequencer and crc
    bcf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_tx_byte   (m_tx_byte),
        .m_run_last  (m_run_last),
        .m_frame_end (m_frame_end)
    );

endmodule
`default_nettype wire

>>> rtl/bcf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_checker
// Port-level checks for the command framer, bound to the top level.
// ----------------------------------------------------------------------------
module bcf_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_valid,
    input wire        m_ready,
    input wire [7:0]  m_tx_byte,
    input wire        m_run_last,
    input wire        m_frame_end
);

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // the frame's last crc byte always ends the item's run
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_run_last)
        else $error("frame end without run last");

    // two frame ends are never back to back
    a_frame_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_frame_end |=> !(m_valid && m_frame_end))
        else $error("frame end twice in a row");

    // stalled transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte)
            && $stable(m_run_last) && $stable(m_frame_end))
        else $error("output changed while stalled");

endmodule

bind bootloader_command_framer_unit bcf_checker u_bcf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_tx_byte   (m_tx_byte),
    .m_run_last  (m_run_last),
    .m_frame_end (m_frame_end)
);
`default_nettype wire
